@@ rtl/tgc_pkg.sv @@
// Shared types and constants of the tap gesture classifier.
`default_nettype none

package tgc_pkg;

	typedef enum logic [2:0] {
		CMD_TICK    = 3'd0,
		CMD_PRESS   = 3'd1,
		CMD_MOVE    = 3'd2,
		CMD_RELEASE = 3'd3,
		CMD_DOUBLE  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		GEST_SINGLE = 2'd0,
		GEST_LONG   = 2'd1,
		GEST_DOUBLE = 2'd2
	} gesture_t;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_LONG_PRESS   = 2'd0;
	localparam logic [1:0] REG_DOUBLE_CLICK = 2'd1;
	localparam logic [1:0] REG_DRAG_LIMIT   = 2'd2;

	localparam logic [15:0] LONG_PRESS_RESET   = 16'd500;
	localparam logic [15:0] DOUBLE_CLICK_RESET = 16'd400;
	localparam logic [15:0] DRAG_LIMIT_RESET   = 16'd10;

	typedef struct packed {
		logic [15:0] long_press_ticks;
		logic [15:0] double_click_ticks;
		logic [15:0] drag_limit;
	} cfg_t;

	typedef struct packed {
		logic [2:0]         command;
		logic               from_child;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
	} item_t;

	typedef struct packed {
		gesture_t           gesture;
		logic signed [15:0] gesture_x;
		logic signed [15:0] gesture_y;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/tgc_apb_regs.sv @@
// Configuration registers of the tap gesture classifier behind an APB-style port.
`default_nettype none

module tgc_apb_regs
	import tgc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output cfg_t             cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press_ticks   <= LONG_PRESS_RESET;
			cfg_q.double_click_ticks <= DOUBLE_CLICK_RESET;
			cfg_q.drag_limit         <= DRAG_LIMIT_RESET;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_LONG_PRESS:   cfg_q.long_press_ticks   <= pwdata[15:0];
				REG_DOUBLE_CLICK: cfg_q.double_click_ticks <= pwdata[15:0];
				REG_DRAG_LIMIT:   cfg_q.drag_limit         <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_LONG_PRESS:   prdata = {16'd0, cfg_q.long_press_ticks};
			REG_DOUBLE_CLICK: prdata = {16'd0, cfg_q.double_click_ticks};
			REG_DRAG_LIMIT:   prdata = {16'd0, cfg_q.drag_limit};
			default:          prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/tgc_core.sv @@
// Gesture state and the combinational decision logic for one event.
`default_nettype none

module tgc_core
	import tgc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic fire,
	input  item_t     item,
	input  cfg_t      cfg,
	output logic      has_result,
	output result_t   result
);

	logic [15:0]        long_press_left_q, long_press_left_d;
	logic [15:0]        click_wait_left_q, click_wait_left_d;
	logic               long_press_done_q, long_press_done_d;
	logic signed [15:0] press_x_q, press_x_d, press_y_q, press_y_d;
	logic signed [15:0] click_x_q, click_x_d, click_y_q, click_y_d;

	logic signed [16:0] dx, dy;
	logic [15:0]        ax, ay;
	logic [16:0]        manhattan;
	logic               lp_exp, cw_exp;
	logic [15:0]        lp_dec, cw_dec;
	logic [15:0]        lp_start, cw_start;

	// Manhattan distance from the stored press; each absolute value fits 16 bits.
	assign dx        = {item.pos_x[15], item.pos_x} - {press_x_q[15], press_x_q};
	assign dy        = {item.pos_y[15], item.pos_y} - {press_y_q[15], press_y_q};
	assign ax        = dx[16] ? 16'(-dx) : dx[15:0];
	assign ay        = dy[16] ? 16'(-dy) : dy[15:0];
	assign manhattan = {1'b0, ax} + {1'b0, ay};

	assign lp_exp   = (long_press_left_q == 16'd1);
	assign cw_exp   = (click_wait_left_q == 16'd1);
	assign lp_dec   = (long_press_left_q != 16'd0) ? long_press_left_q - 16'd1 : 16'd0;
	assign cw_dec   = (click_wait_left_q != 16'd0) ? click_wait_left_q - 16'd1 : 16'd0;
	assign lp_start = (cfg.long_press_ticks == 16'd0) ? 16'd1 : cfg.long_press_ticks;
	assign cw_start = (cfg.double_click_ticks == 16'd0) ? 16'd1 : cfg.double_click_ticks;

	always_comb begin
		long_press_left_d = long_press_left_q;
		click_wait_left_d = click_wait_left_q;
		long_press_done_d = long_press_done_q;
		press_x_d         = press_x_q;
		press_y_d         = press_y_q;
		click_x_d         = click_x_q;
		click_y_d         = click_y_q;
		has_result        = 1'b0;
		result.gesture    = GEST_SINGLE;
		result.gesture_x  = click_x_q;
		result.gesture_y  = click_y_q;

		unique case (cmd_t'(item.command))
			CMD_TICK: begin
				long_press_left_d = lp_dec;
				click_wait_left_d = cw_dec;
				// A long press expiring on the same tick wins over the click.
				if (lp_exp) begin
					long_press_done_d = 1'b1;
					click_wait_left_d = 16'd0;
					has_result        = 1'b1;
					result.gesture    = GEST_LONG;
					result.gesture_x  = press_x_q;
					result.gesture_y  = press_y_q;
				end else if (cw_exp) begin
					has_result = 1'b1;
				end
			end
			CMD_PRESS: begin
				press_x_d         = item.pos_x;
				press_y_d         = item.pos_y;
				long_press_done_d = 1'b0;
				long_press_left_d = lp_start;
			end
			CMD_DOUBLE: begin
				if (item.from_child) begin
					long_press_left_d = 16'd0;
					click_wait_left_d = 16'd0;
					has_result        = 1'b1;
					result.gesture    = GEST_DOUBLE;
					result.gesture_x  = item.pos_x;
					result.gesture_y  = item.pos_y;
				end
			end
			CMD_MOVE: begin
				if (!item.from_child && manhattan > {1'b0, cfg.drag_limit}) begin
					long_press_left_d = 16'd0;
				end
			end
			CMD_RELEASE: begin
				if (!item.from_child) begin
					long_press_left_d = 16'd0;
					long_press_done_d = 1'b0;
					if (!long_press_done_q && manhattan < {1'b0, cfg.drag_limit}) begin
						click_x_d         = item.pos_x;
						click_y_d         = item.pos_y;
						click_wait_left_d = cw_start;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_left_q <= 16'd0;
			click_wait_left_q <= 16'd0;
			long_press_done_q <= 1'b0;
			press_x_q         <= 16'sd0;
			press_y_q         <= 16'sd0;
			click_x_q         <= 16'sd0;
			click_y_q         <= 16'sd0;
		end else if (fire) begin
			long_press_left_q <= long_press_left_d;
			click_wait_left_q <= click_wait_left_d;
			long_press_done_q <= long_press_done_d;
			press_x_q         <= press_x_d;
			press_y_q         <= press_y_d;
			click_x_q         <= click_x_d;
			click_y_q         <= click_y_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/tap_gesture_classifier.sv @@
// Top level of the tap gesture classifier: input register, core, result register.
//
//   channel   direction  handshake                 contents
//   s_axis    in         tvalid/tready             pointer event or tick
//   m_axis    out        tvalid/tready             classified gesture
//   apb       in/out     psel/penable, pready = 1  three timing and distance registers
//
// One event per cycle is accepted unless the output stalls; its transfer loads the input
// register, and as it advances its gesture, if any, is loaded into the output register.
// The gesture state is updated in the cycle an event leaves the input register.
// A stalled output holds the input register; the event behind it waits there.
// Reset is asynchronous and clears all control state; no clearing pass.
`default_nettype none

module tap_gesture_classifier
	import tgc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // [15:0] pos_x, [31:16] pos_y
	input  wire logic [3:0]  s_axis_tuser,  // [2:0] command, [3] from_child
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [31:0] m_axis_tdata,  // [15:0] gesture_x, [31:16] gesture_y
	output logic      [1:0]  m_axis_tuser,  // [1:0] gesture
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	logic    has_result;
	result_t result;
	result_t out_q;
	logic    out_valid_q;

	tgc_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The event in the input register moves on whenever the result register is free or being taken.
	assign advance       = valid_s1 & (~out_valid_q | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.command    <= s_axis_tuser[2:0];
			item_s1.from_child <= s_axis_tuser[3];
			item_s1.pos_x      <= s_axis_tdata[15:0];
			item_s1.pos_y      <= s_axis_tdata[31:16];
		end
	end

	tgc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (advance),
		.item       (item_s1),
		.cfg        (cfg),
		.has_result (has_result),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= has_result;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.gesture;
	assign m_axis_tdata  = {out_q.gesture_y, out_q.gesture_x};

endmodule

`default_nettype wire

@@ rtl/tgc_checker.sv @@
// Port-level checks of the tap gesture classifier and their binding to the top level.
`default_nettype none

module tgc_checker
	import tgc_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [31:0] s_axis_tdata,
	input wire logic [3:0]  s_axis_tuser,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata,
	input wire logic [1:0]  m_axis_tuser
);

	logic in_xfer;
	logic child_double;
	logic plain_press;

	assign in_xfer      = s_axis_tvalid & s_axis_tready;
	assign child_double = in_xfer & (s_axis_tuser[2:0] == CMD_DOUBLE) & s_axis_tuser[3];
	assign plain_press  = in_xfer & (s_axis_tuser[2:0] == CMD_PRESS);

	// A stalled result transfer keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	a_gesture_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == GEST_SINGLE || m_axis_tuser == GEST_LONG ||
			m_axis_tuser == GEST_DOUBLE))
		else $error("unknown gesture code");

	// A child double click comes out with its own position once the output is free.
	a_double_out: assert property (@(posedge clk) disable iff (!arst_n)
		child_double ##1 (m_axis_tready || !m_axis_tvalid) |=>
			m_axis_tvalid && m_axis_tuser == GEST_DOUBLE &&
			m_axis_tdata == $past(s_axis_tdata, 2))
		else $error("double click not reported");

	// A press never produces a gesture of its own.
	a_press_silent: assert property (@(posedge clk) disable iff (!arst_n)
		plain_press ##1 (m_axis_tready || !m_axis_tvalid) |=> !m_axis_tvalid)
		else $error("press produced a gesture");

endmodule

bind tap_gesture_classifier tgc_checker u_tgc_checker (.*);

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for the tap gesture classifier: directed table, random gesture bursts.
`timescale 1ns / 100ps

module testbench
	import tgc_pkg::*;
;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;
	localparam int PIPE_CYCLES    = 6;
	localparam int DIR_ROWS       = 27;
	localparam int PHASES         = 7;

	// Command codes outside the defined set; the block ignores them.
	localparam logic [2:0] CMD_SPARE_LO = 3'd5;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;

	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_NONE,
		ROW_GIVES
	} row_check_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic        child;
		logic [15:0] x;
		logic [15:0] y;
		row_check_t  chk;
		gesture_t    g;
		logic [15:0] gx;
		logic [15:0] gy;
	} dir_row_t;

	typedef struct packed {
		logic [15:0] lp;
		logic [15:0] dc;
		logic [15:0] drag;
		int          send_pct;
		int          recv_pct;
		int          items;
		bit          hold;
	} phase_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // [15:0] pos_x, [31:16] pos_y
	logic [3:0]  s_axis_tuser;   // [2:0] command, [3] from_child
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // [15:0] gesture_x, [31:16] gesture_y
	logic [1:0]  m_axis_tuser;   // [1:0] gesture
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	tap_gesture_classifier dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #5 clk = ~clk;

	// Predictor copy of the registers and the gesture state.
	cfg_t               cfg = '{LONG_PRESS_RESET, DOUBLE_CLICK_RESET, DRAG_LIMIT_RESET};
	logic [15:0]        lp_left = '0;
	logic [15:0]        cw_left = '0;
	bit                 lp_fired = 1'b0;
	logic signed [15:0] press_x = '0;
	logic signed [15:0] press_y = '0;
	logic signed [15:0] click_x = '0;
	logic signed [15:0] click_y = '0;

	result_t  pending_gestures[$];
	int       mismatch_count = 0;
	int       sent_items = 0;
	int       quiet_cycles = 0;
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;
	bit       hold_req = 1'b0;
	bit       hold_done = 1'b0;
	dir_row_t dir_rows [DIR_ROWS];
	phase_t   phases [PHASES];

	function automatic int distance_from_press(logic signed [15:0] x, logic signed [15:0] y);
		int dx;
		int dy;
		dx = int'(x) - int'(press_x);
		dy = int'(y) - int'(press_y);
		return (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
	endfunction

	function automatic logic [15:0] at_least_one(logic [15:0] v);
		return (v == 16'd0) ? 16'd1 : v;
	endfunction

	// Advances the gesture state by one event; returns 1 when a gesture comes out.
	function automatic bit classify(input item_t it, output result_t r);
		bit lp_exp;
		bit cw_exp;
		lp_exp = 1'b0;
		cw_exp = 1'b0;
		r = '0;
		classify = 1'b0;
		case (it.command)
			CMD_TICK: begin
				if (lp_left != 16'd0) begin
					lp_left = lp_left - 16'd1;
					lp_exp = (lp_left == 16'd0);
				end
				if (cw_left != 16'd0) begin
					cw_left = cw_left - 16'd1;
					cw_exp = (cw_left == 16'd0);
				end
				// When both run out together the long press takes precedence.
				if (lp_exp) begin
					lp_fired = 1'b1;
					cw_left = '0;
					r = '{GEST_LONG, press_x, press_y};
					classify = 1'b1;
				end else if (cw_exp) begin
					r = '{GEST_SINGLE, click_x, click_y};
					classify = 1'b1;
				end
			end
			CMD_PRESS: begin
				press_x = it.pos_x;
				press_y = it.pos_y;
				lp_fired = 1'b0;
				lp_left = at_least_one(cfg.long_press_ticks);
			end
			CMD_DOUBLE: begin
				if (it.from_child) begin
					cw_left = '0;
					lp_left = '0;
					r = '{GEST_DOUBLE, it.pos_x, it.pos_y};
					classify = 1'b1;
				end
			end
			CMD_MOVE: begin
				if (!it.from_child && distance_from_press(it.pos_x, it.pos_y) > int'(cfg.drag_limit))
					lp_left = '0;
			end
			CMD_RELEASE: begin
				if (!it.from_child) begin
					lp_left = '0;
					if (!lp_fired && distance_from_press(it.pos_x, it.pos_y) < int'(cfg.drag_limit)) begin
						click_x = it.pos_x;
						click_y = it.pos_y;
						cw_left = at_least_one(cfg.double_click_ticks);
					end
					lp_fired = 1'b0;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic item_t ev(logic [2:0] c, logic ch, logic [15:0] x, logic [15:0] y);
		return '{c, ch, x, y};
	endfunction

	function automatic logic [15:0] near(logic [15:0] b, int spread);
		return b + 16'(int'($urandom_range(spread)) - spread / 2);
	endfunction

	function automatic logic [15:0] pick_base();
		case ($urandom_range(7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
		if (mismatch_count < 100)
			$display("mismatch on %s: got %h, expected %h", field, got, want);
		mismatch_count++;
	endtask

	// Offers one event, waits for its transfer, then records what it should produce.
	task automatic send(input item_t it, input row_check_t chk, input result_t typed);
		result_t r;
		bit      has;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= $urandom;
			s_axis_tuser  <= 4'($urandom);
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {it.pos_y, it.pos_x};
		s_axis_tuser  <= {it.from_child, it.command};
		do @(posedge clk); while (!s_axis_tready);
		has = classify(it, r);
		if (chk == ROW_GIVES)
			pending_gestures.push_back(typed);
		else if (chk == ROW_PREDICT && has)
			pending_gestures.push_back(r);
		sent_items++;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'($urandom), value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_LONG_PRESS:   cfg.long_press_ticks = value;
			REG_DOUBLE_CLICK: cfg.double_click_ticks = value;
			REG_DRAG_LIMIT:   cfg.drag_limit = value;
			default: ;
		endcase
	endtask

	// Stops offering and lets every expected gesture and any event still in flight drain.
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_gestures.size() != 0);
		repeat (PIPE_CYCLES) @(posedge clk);
	endtask

	// Result side: random backpressure, plus one long hold-off on request.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_gestures.size() == 0) begin
				report_mismatch("unexpected gesture", 16'(m_axis_tuser), 16'hxxxx);
			end else begin
				want = pending_gestures.pop_front();
				if (m_axis_tuser !== want.gesture)
					report_mismatch("gesture", 16'(m_axis_tuser), 16'(want.gesture));
				if (m_axis_tdata[15:0] !== want.gesture_x)
					report_mismatch("gesture_x", m_axis_tdata[15:0], want.gesture_x);
				if (m_axis_tdata[31:16] !== want.gesture_y)
					report_mismatch("gesture_y", m_axis_tdata[31:16], want.gesture_y);
			end
		end
	end

	// A transfer on either side resets the count of quiet cycles.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		result_t typed;
		phase_t  ph;
		int      spread;
		int      lp_cap;
		int      dc_cap;
		logic [15:0] bx;
		logic [15:0] by;

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;

		// Directed rows assume long press 2, click wait 2, drag limit 10.
		dir_rows = '{
			'{CMD_TICK,     1'b0, 16'h0000, 16'h0000, ROW_NONE,    GEST_SINGLE, 16'h0, 16'h0},
			'{CMD_PRESS,    1'b0, 16'h7FFF, 16'h7FFF, ROW_NONE,    GEST_SINGLE, 16'h0, 16'h0},
			'{CMD_TICK,     1'b0, 16'h0000, 16'h0000, ROW_NONE,    GEST_SINGLE, 16'h0, 16'h0},
			'{CMD_TICK,     1'b0, 16'h0000, 16'h0000, ROW_GIVES,   GEST_LONG, 16'h7FFF, 16'h7FFF},
			'{CMD_RELEASE,  1'b0, 16'h7FFF, 16'h7FFF, ROW_NONE,    GEST_SINGLE, 16'h0, 16'h0},
			'{CMD_PRESS,    1'b0, 16'h8000, 16'h8000, ROW_NONE,    GEST_SINGLE, 16'h0, 16'h0},
			'{CMD_MOVE,     1'b0, 16'h8005, 16'h8005, ROW_PREDICT, GEST_SINGLE, 16'h0, 16'h0},
			'{CMD_RELEASE,  1'b0, 16'h8004, 16'h8005, ROW_PREDICT, GEST_SINGLE, 16'h0, 16'h0},
			'{CMD_TICK,     1'b0, 16'hFFFF, 16'hFFFF, ROW_PREDICT, GEST_SINGLE, 16'h0, 16'h0},
			'{CMD_TICK,     1'b0, 16'h0000, 16'h0000, ROW_PREDICT, GEST_SINGLE, 16'h0, 16'h0},
			'{CMD_PRESS,    1'b1, 16'h0064, 16'h0064, ROW_PREDICT, GEST_SINGLE, 16'h0, 16'h0},
			'{CMD_MOVE,     1'b1, 16'h7530, 16'h7530, ROW_PREDICT, GEST_SINGLE, 16'h0, 16'h0},
			'{CMD_RELEASE,  1'b1, 16'h7530, 16'h7530, ROW_PREDICT, GEST_SINGLE, 16'h0, 16'h0},
			'{CMD_TICK,     1'b0, 16'h0000, 16'h0000, ROW_PREDICT, GEST_SINGLE, 16'h0, 16'h0},
			'{CMD_TICK,     1'b0, 16'h0000, 16'h0000, ROW_PREDICT, GEST_SINGLE, 16'h0, 16'h0},
			'{CMD_PRESS,    1'b0, 16'h0000, 16'h0000, ROW_PREDICT, GEST_SINGLE, 16'h0, 16'h0},
			'{CMD_MOVE,     1'b0, 16'h000B, 16'h0000, ROW_PREDICT, GEST_SINGLE, 16'h0, 16'h0},
			'{CMD_TICK,     1'b0, 16'h0000, 16'h0000, ROW_PREDICT, GEST_SINGLE, 16'h0, 16'h0},
			'{CMD_TICK,     1'b0, 16'h0000, 16'h0000, ROW_PREDICT, GEST_SINGLE, 16'h0, 16'h0},
			'{CMD_RELEASE,  1'b0, 16'h0000, 16'h0000, ROW_PREDICT, GEST_SINGLE, 16'h0, 16'h0},
			'{CMD_PRESS,    1'b0, 16'h0000, 16'h0000, ROW_PREDICT, GEST_SINGLE, 16'h0, 16'h0},
			'{CMD_TICK,     1'b1, 16'h0000, 16'h0000, ROW_PREDICT, GEST_SINGLE, 16'h0, 16'h0},
			'{CMD_TICK,     1'b0, 16'h0000, 16'h0000, ROW_PREDICT, GEST_SINGLE, 16'h0, 16'h0},
			'{CMD_DOUBLE,   1'b1, 16'h7FFF, 16'h8000, ROW_GIVES,   GEST_DOUBLE, 16'h7FFF, 16'h8000},
			'{CMD_DOUBLE,   1'b0, 16'h1234, 16'h5678, ROW_NONE,    GEST_SINGLE, 16'h0, 16'h0},
			'{CMD_SPARE_LO, 1'b1, 16'hFFFF, 16'hFFFF, ROW_NONE,    GEST_SINGLE, 16'h0, 16'h0},
			'{CMD_SPARE_HI, 1'b0, 16'hFFFF, 16'h0000, ROW_NONE,    GEST_SINGLE, 16'h0, 16'h0}
		};

		// Long press, click wait, drag limit, sender idle %, receiver stall %, events, hold-off.
		phases = '{
			'{16'd5,     16'd3,     16'd8,     0,  0,  200, 1'b1},
			'{16'd12,    16'd6,     16'd20,    48, 0,  250, 1'b0},
			'{16'd1,     16'd1,     16'd0,     0,  48, 150, 1'b0},
			'{16'd0,     16'd0,     16'd3,     23, 23, 120, 1'b0},
			'{16'hFFFF,  16'hFFFF,  16'hFFFF,  0,  0,  150, 1'b0},
			'{16'd8,     16'd4,     16'd40,    23, 23, 400, 1'b0},
			'{16'd20,    16'd10,    16'd15,    0,  48, 250, 1'b0}
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(REG_LONG_PRESS, 16'd2);
		write_reg(REG_DOUBLE_CLICK, 16'd2);
		write_reg(REG_DRAG_LIMIT, 16'd10);
		for (int i = 0; i < DIR_ROWS; i++) begin
			typed = '{dir_rows[i].g, dir_rows[i].gx, dir_rows[i].gy};
			send(ev(dir_rows[i].cmd, dir_rows[i].child, dir_rows[i].x, dir_rows[i].y),
				dir_rows[i].chk, typed);
		end
		drain();

		for (int p = 0; p < PHASES; p++) begin
			ph = phases[p];
			write_reg(REG_LONG_PRESS, ph.lp);
			write_reg(REG_DOUBLE_CLICK, ph.dc);
			write_reg(REG_DRAG_LIMIT, ph.drag);
			send_idle_pct  = ph.send_pct;
			recv_stall_pct = ph.recv_pct;
			hold_req       = ph.hold;
			spread = (ph.drag > 16000) ? 32767 : int'(ph.drag) * 2 + 3;
			lp_cap = (ph.lp > 28) ? 30 : int'(ph.lp) + 2;
			dc_cap = (ph.dc > 28) ? 30 : int'(ph.dc) + 2;
			sent_items = 0;
			while (sent_items < ph.items) begin
				if ($urandom_range(99) < 20) begin
					send(ev(3'($urandom_range(7)), 1'($urandom_range(1)), 16'($urandom),
						16'($urandom)), ROW_PREDICT, '0);
				end else begin
					// A press, a few moves and ticks, a release, then maybe a double click.
					bx = pick_base();
					by = pick_base();
					send(ev(CMD_PRESS, $urandom_range(9) == 0, bx, by), ROW_PREDICT, '0);
					repeat ($urandom_range(3))
						send(ev(CMD_MOVE, $urandom_range(9) == 0, near(bx, spread),
							near(by, spread)), ROW_PREDICT, '0);
					repeat ($urandom_range(lp_cap))
						send(ev(CMD_TICK, 1'($urandom_range(1)), 16'($urandom), 16'($urandom)),
							ROW_PREDICT, '0);
					send(ev(CMD_RELEASE, $urandom_range(9) == 0, near(bx, spread),
						near(by, spread)), ROW_PREDICT, '0);
					repeat ($urandom_range(dc_cap))
						send(ev(CMD_TICK, 1'($urandom_range(1)), 16'($urandom), 16'($urandom)),
							ROW_PREDICT, '0);
					if ($urandom_range(2) == 0)
						send(ev(CMD_DOUBLE, $urandom_range(3) != 0, near(bx, spread),
							near(by, spread)), ROW_PREDICT, '0);
				end
			end
			drain();
		end

		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ tap_gesture_classifier.f @@
rtl/tgc_pkg.sv
rtl/tgc_apb_regs.sv
rtl/tgc_core.sv
rtl/tap_gesture_classifier.sv
rtl/tgc_checker.sv
bench/testbench.sv
